// ----- src/yrm_pkg.sv -----
// package for the yuv422 region mosaic block
// types, sizes, register indices and command codes used by all modules but yrm_ram; no dependencies
package yrm_pkg;

  localparam int MAX_FRAME_WIDTH  = 1024;
  localparam int MAX_FRAME_HEIGHT = 512;
  localparam int MASK_LIMIT       = 2000;

  localparam int LINE_MAX    = MAX_FRAME_WIDTH / 2;
  localparam int FRAME_DEPTH = LINE_MAX * MAX_FRAME_HEIGHT;
  localparam int TILE_DEPTH  = LINE_MAX * ((MAX_FRAME_HEIGHT + 1) / 2);
  localparam int POS_W       = $clog2(FRAME_DEPTH + 1);
  localparam int FADDR_W     = $clog2(FRAME_DEPTH);
  localparam int TADDR_W     = $clog2(TILE_DEPTH);
  localparam int XW          = $clog2(LINE_MAX + 1);
  localparam int YW          = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int DEN_W       = 11;
  localparam int CFG_W       = 11;
  localparam int NUM_REGS    = 8;
  localparam int IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RECT_LEFT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RECT_TOP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MASK_WIDTH   = 3'd6;
  localparam logic [IDX_W-1:0] REG_MASK_HEIGHT  = 3'd7;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic       command;
    logic       frame_start;
    logic [7:0] in_luma_even;
    logic [7:0] in_chroma_u;
    logic [7:0] in_luma_odd;
    logic [7:0] in_chroma_v;
  } in_t;

  typedef struct packed {
    logic [7:0] out_luma_even;
    logic [7:0] out_chroma_u;
    logic [7:0] out_luma_odd;
    logic [7:0] out_chroma_v;
    logic       last_of_frame;
  } out_t;

  typedef struct packed {
    logic [XW-1:0]    fw;
    logic [YW-1:0]    fh;
    logic [XW-1:0]    x0;
    logic [YW-1:0]    y0;
    logic [XW-1:0]    rw;
    logic [YW-1:0]    rh;
    logic [DEN_W-1:0] mw;
    logic [DEN_W-1:0] mh;
    logic             ok;
  } geo_t;

  typedef struct packed {
    logic               command;
    logic               last;
    logic [FADDR_W-1:0] pos;
    logic               tvalid;
    logic               first;
    logic [TADDR_W-1:0] idx;
    logic [31:0]        pix;
  } job_t;

endpackage

// ----- src/yuv422_region_mosaic_core.sv -----
// top level of the yuv422 region mosaic block
// uses yrm_pkg, yrm_front, yrm_jobq, yrm_back
//
// usage: requests enter on in_push/in_full/in_data. a load request stores one
// macropixel (y0 u y1 v) at the next raster position and folds it into its
// mosaic tile average; a fetch request returns the next raster macropixel,
// tile pixels replaced by the tile average, on out_empty/out_pop/out_data.
// frame_start restarts the position of that request's pass.
// configuration: cfg_we writes cfg_data into register cfg_index; the user must
// write only while no request is in flight, the block does not enforce this.
// timing: the front takes one request at a time; locating the tile uses a
// shared one-bit-per-cycle divider over 19 steps, run once for pixels outside
// the rectangle and four times inside it. the back's store access is
// overlapped with the next request through a two-entry queue.
// reset: positions go to zero, registers to their defaults, queues empty;
// store contents are undefined until loaded.
// stall: with out_pop low, up to two results wait in the result queue, then
// the back and then the front hold and in_full stays high.
module yuv422_region_mosaic_core
  import yrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_t              in_data,
  output logic             out_empty,
  input  logic             out_pop,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [CFG_W-1:0] reg_r [NUM_REGS];
  geo_t             geo_r, geo_nxt;
  logic [POS_W-1:0] total_r, total_nxt;
  logic             jq_push, jq_full, jq_pop, jq_empty;
  job_t             jq_in, jq_head;
  logic [11:0]      fw, fh, x0, y0, rw, rh, mwp, mw, mh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[REG_FRAME_WIDTH]  <= CFG_W'(1024);
      reg_r[REG_FRAME_HEIGHT] <= CFG_W'(512);
      reg_r[REG_RECT_LEFT]    <= '0;
      reg_r[REG_RECT_TOP]     <= '0;
      reg_r[REG_RECT_WIDTH]   <= '0;
      reg_r[REG_RECT_HEIGHT]  <= '0;
      reg_r[REG_MASK_WIDTH]   <= CFG_W'(20);
      reg_r[REG_MASK_HEIGHT]  <= CFG_W'(20);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_HEIGHT: reg_r[cfg_index] <= {1'b0, cfg_data[9:0]};
        REG_RECT_LEFT:    reg_r[cfg_index] <= {1'b0, cfg_data[9:0]};
        REG_RECT_TOP:     reg_r[cfg_index] <= {2'b0, cfg_data[8:0]};
        REG_RECT_HEIGHT:  reg_r[cfg_index] <= {1'b0, cfg_data[9:0]};
        default:          reg_r[cfg_index] <= cfg_data;
      endcase
    end
    geo_r   <= geo_nxt;
    total_r <= total_nxt;
  end

  always_comb begin
    fw = 12'(reg_r[REG_FRAME_WIDTH] >> 1);
    if (fw < 12'd1) fw = 12'd1;
    if (fw > 12'(LINE_MAX)) fw = 12'(LINE_MAX);
    fh = 12'(reg_r[REG_FRAME_HEIGHT]);
    if (fh < 12'd1) fh = 12'd1;
    if (fh > 12'(MAX_FRAME_HEIGHT)) fh = 12'(MAX_FRAME_HEIGHT);
    total_nxt = POS_W'(fw) * POS_W'(fh);
    x0 = 12'(reg_r[REG_RECT_LEFT] >> 1);
    y0 = 12'(reg_r[REG_RECT_TOP]);
    rw = 12'(reg_r[REG_RECT_WIDTH] >> 1);
    if (rw > fw - x0) rw = fw - x0;
    rh = 12'(reg_r[REG_RECT_HEIGHT]);
    if (rh > fh - y0) rh = fh - y0;
    mwp = 12'(reg_r[REG_MASK_WIDTH]);
    if (mwp < 12'd1) mwp = 12'd1;
    if (mwp > {rw[10:0], 1'b0}) mwp = {rw[10:0], 1'b0};
    if (mwp > 12'(MASK_LIMIT)) mwp = 12'(MASK_LIMIT);
    mw = mwp >> 1;
    if (mw < 12'd1) mw = 12'd1;
    mh = 12'(reg_r[REG_MASK_HEIGHT]);
    if (mh < 12'd1) mh = 12'd1;
    if (mh > rh) mh = rh;
    if (mh > 12'(MASK_LIMIT)) mh = 12'(MASK_LIMIT);
    geo_nxt.ok = x0 < fw && y0 < fh && rw != 12'd0 && rh != 12'd0;
    geo_nxt.fw = XW'(fw);
    geo_nxt.fh = YW'(fh);
    geo_nxt.x0 = XW'(x0);
    geo_nxt.y0 = YW'(y0);
    geo_nxt.rw = XW'(rw);
    geo_nxt.rh = YW'(rh);
    geo_nxt.mw = DEN_W'(mw);
    geo_nxt.mh = DEN_W'(mh);
  end

  yrm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .geo(geo_r), .total(total_r),
    .jq_push(jq_push), .jq_full(jq_full), .jq_data(jq_in)
  );

  yrm_jobq u_jobq (
    .clk(clk), .rst_n(rst_n), .push(jq_push), .push_data(jq_in), .full(jq_full),
    .pop(jq_pop), .empty(jq_empty), .head(jq_head)
  );

  yrm_back u_back (
    .clk(clk), .rst_n(rst_n), .jq_pop(jq_pop), .jq_empty(jq_empty),
    .jq_head(jq_head), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );
endmodule

// ----- src/yrm_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module yrm_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ----- src/yrm_front.sv -----
// front end: accepts requests, tracks raster positions, locates the mosaic tile
// uses yrm_pkg; shares one bit-serial divider across the tile lookups
module yrm_front
  import yrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_t              in_data,
  input  geo_t             geo,
  input  logic [POS_W-1:0] total,
  output logic             jq_push,
  input  logic             jq_full,
  output job_t             jq_data
);
  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_POS  = 4'd1;
  localparam logic [3:0] F_D1   = 4'd2;
  localparam logic [3:0] F_D2   = 4'd3;
  localparam logic [3:0] F_D3   = 4'd4;
  localparam logic [3:0] F_D4   = 4'd5;
  localparam logic [3:0] F_MUL  = 4'd6;
  localparam logic [3:0] F_FIN  = 4'd7;
  localparam logic [3:0] F_EMIT = 4'd8;
  localparam int CNT_W = $clog2(POS_W);
  localparam int PW    = 2 * DEN_W;

  logic [3:0]       state_r, state_nxt;
  in_t              item_r, item_nxt;
  logic [POS_W-1:0] lpos_r, lpos_nxt, fpos_r, fpos_nxt;
  logic [FADDR_W-1:0] pos_r, pos_nxt;
  logic             last_r, last_nxt;
  logic [POS_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] my_r, my_nxt, tx_r, tx_nxt, ty_r, ty_nxt, tpr_r, tpr_nxt;
  logic             lxz_r, lxz_nxt, lyz_r, lyz_nxt;
  logic [PW-1:0]    p1_r, p1_nxt, p2_r, p2_nxt;
  logic             tvalid_r, tvalid_nxt, first_r, first_nxt;
  logic [TADDR_W-1:0] idx_r, idx_nxt;

  logic [DEN_W:0]   sh;
  logic             ge;
  logic [DEN_W-1:0] r_step;
  logic [POS_W-1:0] q_step;
  logic             div_done;
  logic [POS_W-1:0] pos_c, pos_inc;
  logic             inr;
  logic [PW:0]      idx_w;
  logic [DEN_W:0]   th;

  always_comb begin
    sh       = {rem_r, num_r[POS_W-1]};
    ge       = sh >= {1'b0, den_r};
    r_step   = ge ? DEN_W'(sh - {1'b0, den_r}) : sh[DEN_W-1:0];
    q_step   = {num_r[POS_W-2:0], ge};
    div_done = cnt_r == CNT_W'(POS_W - 1);
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    lpos_nxt   = lpos_r;
    fpos_nxt   = fpos_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    my_nxt     = my_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    tpr_nxt    = tpr_r;
    lxz_nxt    = lxz_r;
    lyz_nxt    = lyz_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    tvalid_nxt = tvalid_r;
    first_nxt  = first_r;
    idx_nxt    = idx_r;
    jq_push    = 1'b0;
    pos_c      = '0;
    pos_inc    = '0;
    inr        = 1'b0;
    idx_w      = '0;
    th         = '0;
    if (state_r != F_IDLE && state_r != F_POS && state_r != F_MUL &&
        state_r != F_FIN && state_r != F_EMIT) begin
      num_nxt = q_step;
      rem_nxt = r_step;
      cnt_nxt = cnt_r + 1'b1;
    end
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          item_nxt  = in_data;
          state_nxt = F_POS;
        end
      end
      F_POS: begin
        pos_c = item_r.frame_start ? '0 : (item_r.command == CMD_FETCH ? fpos_r : lpos_r);
        if (pos_c >= total) pos_c = '0;
        pos_inc  = pos_c + 1'b1;
        last_nxt = pos_inc >= total;
        if (item_r.command == CMD_FETCH) fpos_nxt = last_nxt ? '0 : pos_inc;
        else lpos_nxt = last_nxt ? '0 : pos_inc;
        pos_nxt   = pos_c[FADDR_W-1:0];
        num_nxt   = pos_c;
        den_nxt   = DEN_W'(geo.fw);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = F_D1;
      end
      F_D1: begin
        if (div_done) begin
          my_nxt = DEN_W'(q_step);
          inr = geo.ok && r_step >= DEN_W'(geo.x0) &&
                r_step < DEN_W'(geo.x0) + DEN_W'(geo.rw) &&
                q_step >= POS_W'(geo.y0) &&
                q_step < POS_W'(geo.y0) + POS_W'(geo.rh);
          num_nxt = POS_W'(r_step - DEN_W'(geo.x0));
          den_nxt = geo.mw;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (inr) begin
            state_nxt = F_D2;
          end else begin
            tvalid_nxt = 1'b0;
            state_nxt  = F_EMIT;
          end
        end
      end
      F_D2: begin
        if (div_done) begin
          tx_nxt    = DEN_W'(q_step);
          lxz_nxt   = r_step == '0;
          num_nxt   = POS_W'(my_r - DEN_W'(geo.y0));
          den_nxt   = geo.mh;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_D3;
        end
      end
      F_D3: begin
        if (div_done) begin
          ty_nxt    = DEN_W'(q_step);
          lyz_nxt   = r_step == '0;
          num_nxt   = POS_W'(DEN_W'(geo.rw) + geo.mw - 1'b1);
          den_nxt   = geo.mw;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_D4;
        end
      end
      F_D4: begin
        if (div_done) begin
          tpr_nxt   = DEN_W'(q_step);
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        p1_nxt    = ty_r * geo.mh;
        p2_nxt    = ty_r * tpr_r;
        state_nxt = F_FIN;
      end
      F_FIN: begin
        th         = (DEN_W + 1)'(geo.rh) - (DEN_W + 1)'(p1_r);
        idx_w      = {1'b0, p2_r} + (PW + 1)'(tx_r);
        tvalid_nxt = th >= (DEN_W + 1)'(2) && geo.mh >= DEN_W'(2) &&
                     idx_w < (PW + 1)'(TILE_DEPTH);
        first_nxt  = lxz_r && lyz_r;
        idx_nxt    = idx_w[TADDR_W-1:0];
        state_nxt  = F_EMIT;
      end
      F_EMIT: begin
        if (!jq_full) begin
          jq_push   = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      lpos_r  <= '0;
      fpos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lpos_r  <= lpos_nxt;
      fpos_r  <= fpos_nxt;
    end
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    my_r     <= my_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
    tpr_r    <= tpr_nxt;
    lxz_r    <= lxz_nxt;
    lyz_r    <= lyz_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    tvalid_r <= tvalid_nxt;
    first_r  <= first_nxt;
    idx_r    <= idx_nxt;
  end

  assign in_full = state_r != F_IDLE;

  always_comb begin
    jq_data.command = item_r.command;
    jq_data.last    = last_r;
    jq_data.pos     = pos_r;
    jq_data.tvalid  = tvalid_r;
    jq_data.first   = first_r;
    jq_data.idx     = idx_r;
    jq_data.pix     = {item_r.in_luma_even, item_r.in_chroma_u,
                       item_r.in_luma_odd, item_r.in_chroma_v};
  end
endmodule

// ----- src/yrm_jobq.sv -----
// two-entry request queue between front and back
// uses yrm_pkg
module yrm_jobq
  import yrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);
  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) ent_r[wp_r] <= push_data;
  end

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = ent_r[rp_r];
endmodule

// ----- src/yrm_back.sv -----
// back end: frame and tile stores, tile averaging, result queue
// uses yrm_pkg and yrm_ram
module yrm_back
  import yrm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  output logic jq_pop,
  input  logic jq_empty,
  input  job_t jq_head,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_DO   = 2'd2;

  logic [1:0]  state_r, state_nxt;
  job_t        job_r;
  out_t        ob_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        ob_push;
  out_t        ob_data;

  logic        f_we, f_re, t_we, t_re;
  logic [31:0] f_rd;
  logic [23:0] t_rd, t_wd;
  logic [8:0]  ay, au, av;
  logic [7:0]  y0, u, y1, v;

  yrm_ram #(.W(32), .D(FRAME_DEPTH)) u_frame (
    .clk(clk), .wr_en(f_we), .wr_addr(job_r.pos), .wr_data(job_r.pix),
    .rd_en(f_re), .rd_addr(job_r.pos), .rd_data(f_rd)
  );

  yrm_ram #(.W(24), .D(TILE_DEPTH)) u_tile (
    .clk(clk), .wr_en(t_we), .wr_addr(job_r.idx), .wr_data(t_wd),
    .rd_en(t_re), .rd_addr(job_r.idx), .rd_data(t_rd)
  );

  always_comb begin
    {y0, u, y1, v} = job_r.pix;
    if (job_r.first) begin
      ay = ({1'b0, y0} + {1'b0, y1}) >> 1;
      au = {1'b0, u};
      av = {1'b0, v};
    end else begin
      ay = {1'b0, t_rd[23:16]};
      au = {1'b0, t_rd[15:8]};
      av = {1'b0, t_rd[7:0]};
    end
    ay = (ay + {1'b0, y0}) >> 1;
    au = (au + {1'b0, u}) >> 1;
    ay = (ay + {1'b0, y1}) >> 1;
    av = (av + {1'b0, v}) >> 1;
    t_wd = {ay[7:0], au[7:0], av[7:0]};
  end

  always_comb begin
    if (job_r.tvalid) begin
      ob_data.out_luma_even = t_rd[23:16];
      ob_data.out_chroma_u  = t_rd[15:8];
      ob_data.out_luma_odd  = t_rd[23:16];
      ob_data.out_chroma_v  = t_rd[7:0];
    end else begin
      {ob_data.out_luma_even, ob_data.out_chroma_u,
       ob_data.out_luma_odd, ob_data.out_chroma_v} = f_rd;
    end
    ob_data.last_of_frame = job_r.last;
  end

  always_comb begin
    state_nxt = state_r;
    jq_pop    = 1'b0;
    f_we      = 1'b0;
    f_re      = 1'b0;
    t_we      = 1'b0;
    t_re      = 1'b0;
    ob_push   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!jq_empty) begin
          jq_pop    = 1'b1;
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        f_re      = job_r.command == CMD_FETCH;
        t_re      = job_r.tvalid;
        state_nxt = B_DO;
      end
      B_DO: begin
        if (job_r.command == CMD_LOAD) begin
          f_we      = 1'b1;
          t_we      = job_r.tvalid;
          state_nxt = B_IDLE;
        end else if (cnt_r != 2'd2) begin
          ob_push   = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ob_push) wp_r <= ~wp_r;
      if (out_pop && cnt_r != 2'd0) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, ob_push} - {1'b0, out_pop && cnt_r != 2'd0};
    end
    if (jq_pop) job_r <= jq_head;
    if (ob_push) ob_r[wp_r] <= ob_data;
  end

  assign out_empty = cnt_r == 2'd0;
  assign out_data  = ob_r[rp_r];
endmodule

// ----- src/yrm_checker.sv -----
// port-level checks for the yuv422 region mosaic block
// uses yrm_pkg; bound to yuv422_region_mosaic_core
module yrm_checker
  import yrm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input out_t out_data
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("second request taken while one is in progress");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");
endmodule

bind yuv422_region_mosaic_core yrm_checker u_yrm_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
);
